// File: sv/bfra_pkg.sv
package bfra_pkg;

    localparam int SIZE_W = 13;
    localparam int OFF_W  = 12;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE   = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = 13'd4096;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  release_offset;
    } bfra_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  granted_offset;
        logic [SIZE_W-1:0] top_after;
    } bfra_rsp_t;

    // Start is kept at full arena width so that ranges above offset 4095 stay exact.
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] length;
    } bfra_entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NOP,
        S_ASCAN,
        S_AFIN,
        S_PSCAN,
        S_PMERGE,
        S_NSCAN,
        S_NMERGE,
        S_RFIN
    } bfra_state_t;

endpackage

// File: sv/bfra_mem.sv
module bfra_mem
    import bfra_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  bfra_entry_t       wdata,
    input  logic [AW-1:0]     raddr,
    output bfra_entry_t       rdata
);

    bfra_entry_t entries_reg [DEPTH];
    bfra_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            entries_reg[waddr] <= wdata;
        end
        rdata_reg <= entries_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/bfra_ctrl.sv
module bfra_ctrl
    import bfra_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SIZE_W-1:0] eff_limit,
    input  logic              s_valid,
    output logic              s_ready,
    input  bfra_req_t         s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output bfra_rsp_t         m_payload,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output bfra_entry_t       mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  bfra_entry_t       mem_rdata
);

    localparam logic [AW:0] CNT_END  = (AW + 1)'(DEPTH);
    localparam logic [AW:0] CNT_LAST = (AW + 1)'(DEPTH - 1);

    bfra_state_t       state_reg, state_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic              rvalid_reg, rvalid_next;
    logic [AW-1:0]     ridx_reg, ridx_next;
    logic              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     bidx_reg, bidx_next;
    logic [SIZE_W-1:0] bstart_reg, bstart_next;
    logic [SIZE_W-1:0] blen_reg, blen_next;
    logic              have_free_reg, have_free_next;
    logic [AW-1:0]     fidx_reg, fidx_next;
    logic [SIZE_W-1:0] mo_reg, mo_next;
    logic [SIZE_W:0]   ml_reg, ml_next;
    logic              nmerge_reg, nmerge_next;
    logic [SIZE_W-1:0] top_reg, top_next;
    logic              out_valid_reg, out_valid_next;
    bfra_rsp_t         out_reg, out_next;

    logic              out_free;
    logic              load_out;
    logic [1:0]        rsp_status;
    logic [OFF_W-1:0]  rsp_granted;
    logic [SIZE_W+1:0] merged_end;
    logic              better;

    assign merged_end = {2'b0, mo_reg} + {1'b0, ml_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            rvalid_reg    <= 1'b0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rvalid_reg    <= rvalid_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg      <= ridx_next;
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        off_reg       <= off_next;
        found_reg     <= found_next;
        bidx_reg      <= bidx_next;
        bstart_reg    <= bstart_next;
        blen_reg      <= blen_next;
        have_free_reg <= have_free_next;
        fidx_reg      <= fidx_next;
        mo_reg        <= mo_next;
        ml_reg        <= ml_next;
        nmerge_reg    <= nmerge_next;
        out_reg       <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rvalid_next    = 1'b0;
        ridx_next      = cnt_reg[AW-1:0];
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        found_next     = found_reg;
        bidx_next      = bidx_reg;
        bstart_next    = bstart_reg;
        blen_next      = blen_reg;
        have_free_next = have_free_reg;
        fidx_next      = fidx_reg;
        mo_next        = mo_reg;
        ml_next        = ml_reg;
        nmerge_next    = nmerge_reg;
        top_next       = top_reg;
        out_next       = out_reg;
        out_free       = !out_valid_reg || m_ready;
        out_valid_next = out_valid_reg && !m_ready;
        load_out       = 1'b0;
        rsp_status     = STATUS_OK;
        rsp_granted    = '0;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = bidx_reg;
        mem_wdata      = '{valid: 1'b0, start: bstart_reg, length: blen_reg};
        mem_raddr      = cnt_reg[AW-1:0];
        better         = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next       = s_payload.cmd;
                    size_next      = s_payload.request_size;
                    off_next       = s_payload.release_offset;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    have_free_next = 1'b0;
                    nmerge_next    = 1'b0;
                    if (s_payload.request_size == '0) begin
                        state_next = S_NOP;
                    end else if (s_payload.cmd == CMD_ALLOC) begin
                        state_next = S_ASCAN;
                    end else if (({2'b0, s_payload.release_offset}
                                  + {1'b0, s_payload.request_size}) > {1'b0, top_reg}) begin
                        state_next = S_NOP;
                    end else begin
                        state_next = S_PSCAN;
                    end
                end
            end
            S_NOP: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ASCAN, S_PSCAN, S_NSCAN: begin
                if (cnt_reg != CNT_END) begin
                    rvalid_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    case (state_reg)
                        S_ASCAN: state_next = S_AFIN;
                        S_PSCAN: state_next = S_PMERGE;
                        default: state_next = S_NMERGE;
                    endcase
                end
                if (rvalid_reg) begin
                    case (state_reg)
                        S_ASCAN: begin
                            // Best fit: shortest range that holds the size, lowest start on a tie.
                            better = mem_rdata.valid && (mem_rdata.length >= size_reg) &&
                                     (!found_reg || (mem_rdata.length < blen_reg) ||
                                      ((mem_rdata.length == blen_reg) &&
                                       (mem_rdata.start < bstart_reg)));
                        end
                        S_PSCAN: begin
                            better = mem_rdata.valid &&
                                     (mem_rdata.start < {1'b0, off_reg}) &&
                                     (!found_reg || (mem_rdata.start > bstart_reg));
                        end
                        default: begin
                            better = mem_rdata.valid && (mem_rdata.start >= mo_reg) &&
                                     (!found_reg || (mem_rdata.start < bstart_reg));
                            if (!mem_rdata.valid && !have_free_reg) begin
                                have_free_next = 1'b1;
                                fidx_next      = ridx_reg;
                            end
                        end
                    endcase
                    if (better) begin
                        found_next  = 1'b1;
                        bidx_next   = ridx_reg;
                        bstart_next = mem_rdata.start;
                        blen_next   = mem_rdata.length;
                    end
                end
            end
            S_AFIN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (found_reg) begin
                        rsp_granted = bstart_reg[OFF_W-1:0];
                        mem_we      = 1'b1;
                        if (blen_reg == size_reg) begin
                            mem_wdata.valid = 1'b0;
                        end else begin
                            mem_wdata.valid  = 1'b1;
                            mem_wdata.start  = bstart_reg + size_reg;
                            mem_wdata.length = blen_reg - size_reg;
                        end
                    end else if (({1'b0, top_reg} + {1'b0, size_reg}) <= {1'b0, eff_limit}) begin
                        rsp_granted = top_reg[OFF_W-1:0];
                        top_next    = top_reg + size_reg;
                    end else begin
                        rsp_status = STATUS_NO_SPACE;
                    end
                end
            end
            S_PMERGE: begin
                if (found_reg &&
                    (({1'b0, bstart_reg} + {1'b0, blen_reg}) == {2'b0, off_reg})) begin
                    mo_next = bstart_reg;
                    ml_next = {1'b0, size_reg} + {1'b0, blen_reg};
                    mem_we  = 1'b1;
                end else begin
                    mo_next = {1'b0, off_reg};
                    ml_next = {1'b0, size_reg};
                end
                found_next = 1'b0;
                cnt_next   = '0;
                state_next = S_NSCAN;
            end
            S_NMERGE: begin
                if (found_reg && (merged_end == {2'b0, bstart_reg})) begin
                    ml_next     = ml_reg + {1'b0, blen_reg};
                    nmerge_next = 1'b1;
                    mem_we      = 1'b1;
                end
                state_next = S_RFIN;
            end
            S_RFIN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    mem_wdata  = '{valid: 1'b1, start: mo_reg, length: ml_reg[SIZE_W-1:0]};
                    if (merged_end == {2'b0, top_reg}) begin
                        top_next = mo_reg;
                    end else if (nmerge_reg && (!have_free_reg || (bidx_reg < fidx_reg))) begin
                        // The absorbed next entry is now the lowest free slot.
                        mem_we    = 1'b1;
                        mem_waddr = bidx_reg;
                    end else if (have_free_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = fidx_reg;
                    end else begin
                        rsp_status = STATUS_TABLE_FULL;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
            out_next       = '{status: rsp_status, granted_offset: rsp_granted,
                               top_after: top_next};
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ASCAN || state_reg == S_PSCAN || state_reg == S_NSCAN) |-> !mem_we)
        else $error("free table written during a scan");

    a_top_changes_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(top_reg)) |->
        ($past(state_reg) == S_AFIN || $past(state_reg) == S_RFIN))
        else $error("arena top changed outside a finishing step");

    a_full_means_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && rsp_status == STATUS_TABLE_FULL) |-> (!have_free_reg && !nmerge_reg))
        else $error("table full reported while a slot was free");

    a_read_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> (state_reg == S_ASCAN || state_reg == S_PSCAN || state_reg == S_NSCAN))
        else $error("read data returned outside a scan");

endmodule

// File: sv/best_fit_range_allocator.sv
// Best-fit range allocator. Each beat on s_ carries an allocate or release request and produces
// exactly one result beat on m_. The free-range table lives in a single-port-write, registered-read
// memory of FREE_ENTRIES words, and each request walks it one entry per cycle: an allocate makes
// one best-fit pass, and a release makes a pass for the previous neighbor, then a pass for the next
// neighbor and the first free slot. Zero-size requests and releases past the arena top skip the
// scans. After reset the block clears the table before s_ready rises; pool_limit can be written
// over the APB port at any time during that pass.
module best_fit_range_allocator
    import bfra_pkg::*;
#(
    parameter int POOL_SLOTS   = 4096,
    parameter int FREE_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  bfra_req_t   s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output bfra_rsp_t   m_payload
);

    localparam int AW        = $clog2(FREE_ENTRIES);
    localparam int LIMIT_CAP = (POOL_SLOTS > 8191) ? 8191 : POOL_SLOTS;

    logic [SIZE_W-1:0] pool_limit_reg;
    logic [SIZE_W-1:0] eff_limit;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    bfra_entry_t       mem_wdata;
    bfra_entry_t       mem_rdata;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            pool_limit_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata    = paddr[2] ? '0 : {{(32 - SIZE_W){1'b0}}, pool_limit_reg};
    assign eff_limit = (pool_limit_reg < SIZE_W'(LIMIT_CAP)) ? pool_limit_reg
                                                              : SIZE_W'(LIMIT_CAP);

    bfra_mem #(.DEPTH(FREE_ENTRIES), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfra_ctrl #(.DEPTH(FREE_ENTRIES), .AW(AW)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_limit (eff_limit),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule
